// ----- rtl/blg_pkg.sv -----
// Shared constants and types for the line generator.
// No dependencies; blg_csr_if and every module refer to names here by scope.
package blg_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int VIEW_BITS      = 13;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [VIEW_BITS-1:0] VIEW_WIDTH_RST  = 13'd240;
   localparam logic [VIEW_BITS-1:0] VIEW_HEIGHT_RST = 13'd208;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_STEP  = 1'b1
   } action_type;

   typedef enum logic {
      CSR_VIEW_WIDTH  = 1'b0,
      CSR_VIEW_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_stat_type;

endpackage

// ----- rtl/blg_req_if.sv -----
// Request channel: valid/ready handshake with the line command payload.
// Depends on nothing but its COORD_BITS parameter.
interface blg_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;

   modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

// ----- rtl/blg_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one pixel per transaction.
// Depends on nothing but its COORD_BITS parameter.
interface blg_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         on_screen;
   logic                         last_pixel;

   modport source (output valid, pixel_x, pixel_y, on_screen, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, on_screen, last_pixel, output ready);
endinterface

// ----- rtl/blg_csr_if.sv -----
// Register write channel: valid/ready handshake with index and data.
// Depends on blg_pkg for the data width.
interface blg_csr_if;
   logic                          valid;
   logic                          ready;
   logic                          index;
   logic [blg_pkg::VIEW_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/bresenham_line_generator.sv -----
// Top level of the line generator: view registers, front end, queue, back end.
// Depends on blg_pkg, the three channel interfaces, blg_front, blg_queue, blg_back.
//
// Usage:
//   req_ch carries commands. action START loads a new line from the two
//   endpoints and gives no response; any line in progress is dropped.
//   action STEP gives one pixel on rsp_ch while a line is active and
//   nothing once the pixel flagged last_pixel has been sent.
//   csr_ch writes view_width (index 0) and view_height (index 1); it is
//   always ready and takes effect on the next pixel produced.
// Timing:
//   A transaction enters the two-entry queue on the cycle it is accepted;
//   the back end takes it from the queue head and registers the pixel in
//   the response register, which drives rsp_ch.
//   Throughput is one transaction per cycle while rsp_ch is not held, set
//   by the add/compare/subtract step of the back end.
// Reset:
//   reset clears the queue, the active line and the response valid flag and
//   loads the view registers with 240 by 208.
// Stall:
//   While rsp_ch is held, the pixel holds in the response register, the
//   queue fills and req_ch.ready drops once it is full.
module bresenham_line_generator #(
   parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   blg_req_if.sink   req_ch,
   blg_rsp_if.source rsp_ch,
   blg_csr_if.sink   csr_ch
);

   localparam int ENTRY_W = 4 * COORD_BITS + 2;

   logic [blg_pkg::VIEW_BITS-1:0] view_width_ff,  view_width_in;
   logic [blg_pkg::VIEW_BITS-1:0] view_height_ff, view_height_in;

   logic                    push;
   logic [ENTRY_W-1:0]      push_data;
   logic                    pop;
   logic [ENTRY_W-1:0]      head_data;
   blg_pkg::queue_stat_type stat;

   always_comb begin
      view_width_in  = view_width_ff;
      view_height_in = view_height_ff;
      if (csr_ch.valid) begin
         unique case (blg_pkg::csr_index_type'(csr_ch.index))
            blg_pkg::CSR_VIEW_WIDTH:  view_width_in  = csr_ch.data;
            blg_pkg::CSR_VIEW_HEIGHT: view_height_in = csr_ch.data;
            default: begin
               view_width_in  = view_width_ff;
               view_height_in = view_height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff  <= blg_pkg::VIEW_WIDTH_RST;
         view_height_ff <= blg_pkg::VIEW_HEIGHT_RST;
      end else begin
         view_width_ff  <= view_width_in;
         view_height_ff <= view_height_in;
      end
   end

   assign csr_ch.ready = 1'b1;

   blg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req       (req_ch),
      .stat      (stat),
      .push      (push),
      .push_data (push_data)
   );

   blg_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (blg_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (head_data),
      .stat      (stat)
   );

   blg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_data   (head_data),
      .stat        (stat),
      .pop         (pop),
      .view_width  (view_width_ff),
      .view_height (view_height_ff),
      .rsp         (rsp_ch)
   );

endmodule

// ----- rtl/blg_front.sv -----
// Front end: accepts request transactions, orders endpoints by x and
// forms the raw deltas for the queue. Depends on blg_pkg and blg_req_if.
module blg_front #(
   parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF,
   localparam int ENTRY_W   = 4 * COORD_BITS + 2
) (
   blg_req_if.sink              req,
   input  blg_pkg::queue_stat_type stat,
   output logic                 push,
   output logic [ENTRY_W-1:0]   push_data
);

   logic signed [COORD_BITS-1:0] x0;
   logic signed [COORD_BITS-1:0] y0;
   logic signed [COORD_BITS-1:0] x1;
   logic signed [COORD_BITS-1:0] y1;
   logic signed [COORD_BITS:0]   dx_wide;
   logic signed [COORD_BITS:0]   dy_wide;
   logic                         swap;

   always_comb begin
      swap    = req.x_start > req.x_end;
      x0      = swap ? req.x_end   : req.x_start;
      y0      = swap ? req.y_end   : req.y_start;
      x1      = swap ? req.x_start : req.x_end;
      y1      = swap ? req.y_start : req.y_end;
      dx_wide = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
      dy_wide = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
   end

   assign req.ready = !stat.full;
   assign push      = req.valid && !stat.full;
   assign push_data = {req.action, x0, y0, dx_wide[COORD_BITS-1:0], dy_wide};

endmodule

// ----- rtl/blg_queue.sv -----
// Short register queue between the front end and the stepping back end.
// Depends on blg_pkg for the status struct.
module blg_queue #(
   parameter int WIDTH = 66,
   parameter int DEPTH = blg_pkg::QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output blg_pkg::queue_stat_type stat
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data       = entry_ff[rd_ptr_ff];
   assign stat.not_empty = count_ff != '0;
   assign stat.full      = count_ff == CNT_W'(DEPTH);

endmodule

// ----- rtl/blg_back.sv -----
// Back end: loads line setup from the queue and steps one pixel per
// transaction into the response register. Depends on blg_pkg and blg_rsp_if.
module blg_back #(
   parameter int COORD_BITS = blg_pkg::COORD_BITS_DEF,
   localparam int ENTRY_W   = 4 * COORD_BITS + 2,
   localparam int CMP_W     = (COORD_BITS > blg_pkg::VIEW_BITS) ?
                              COORD_BITS : blg_pkg::VIEW_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ENTRY_W-1:0]            head_data,
   input  blg_pkg::queue_stat_type       stat,
   output logic                          pop,
   input  logic [blg_pkg::VIEW_BITS-1:0] view_width,
   input  logic [blg_pkg::VIEW_BITS-1:0] view_height,
   blg_rsp_if.source                     rsp
);

   localparam int C = COORD_BITS;

   logic                head_action;
   logic signed [C-1:0] head_x0;
   logic signed [C-1:0] head_y0;
   logic [C-1:0]        head_dx;
   logic signed [C:0]   head_dy;

   logic [C-1:0] ady;
   logic         ld_y_down;
   logic         ld_steep;
   logic [C-1:0] ld_major;
   logic [C-1:0] ld_minor;

   logic [C-1:0] cur_x_ff,   cur_x_in;
   logic [C-1:0] cur_y_ff,   cur_y_in;
   logic [C-1:0] major_ff,   major_in;
   logic [C-1:0] minor_ff,   minor_in;
   logic [C:0]   error_ff,   error_in;
   logic [C:0]   left_ff,    left_in;
   logic         y_down_ff,  y_down_in;
   logic         steep_ff,   steep_in;
   logic         active_ff,  active_in;

   logic         rsp_valid_ff,  rsp_valid_in;
   logic [C-1:0] rsp_x_ff,      rsp_x_in;
   logic [C-1:0] rsp_y_ff,      rsp_y_in;
   logic         rsp_on_ff,     rsp_on_in;
   logic         rsp_last_ff,   rsp_last_in;

   logic         out_free;
   logic         emit;
   logic         is_last;
   logic [C:0]   err_sum;
   logic         minor_step;
   logic [C-1:0] y_next;
   logic [C-1:0] x_next;

   always_comb begin
      {head_action, head_x0, head_y0, head_dx, head_dy} = head_data;

      ld_y_down = head_dy[C];
      ady       = ld_y_down ? (~head_dy[C-1:0] + C'(1)) : head_dy[C-1:0];
      ld_steep  = head_dx < ady;
      ld_major  = ld_steep ? ady : head_dx;
      ld_minor  = ld_steep ? head_dx : ady;

      out_free  = !rsp_valid_ff || rsp.ready;
      emit      = stat.not_empty && (head_action == blg_pkg::ACT_STEP) && active_ff
                  && out_free;
      pop       = stat.not_empty && ((head_action == blg_pkg::ACT_START) || !active_ff
                  || out_free);

      is_last    = left_ff == (C+1)'(1);
      err_sum    = error_ff + {1'b0, minor_ff};
      minor_step = err_sum >= {1'b0, major_ff};
      y_next     = y_down_ff ? (cur_y_ff - C'(1)) : (cur_y_ff + C'(1));
      x_next     = cur_x_ff + C'(1);

      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      error_in  = error_ff;
      left_in   = left_ff;
      y_down_in = y_down_ff;
      steep_in  = steep_ff;
      active_in = active_ff;

      if (pop && (head_action == blg_pkg::ACT_START)) begin
         cur_x_in  = head_x0;
         cur_y_in  = head_y0;
         major_in  = ld_major;
         minor_in  = ld_minor;
         error_in  = {2'b00, ld_major[C-1:1]};
         left_in   = {1'b0, ld_major} + (C+1)'(1);
         y_down_in = ld_y_down;
         steep_in  = ld_steep;
         active_in = 1'b1;
      end else if (emit) begin
         if (is_last) begin
            left_in   = '0;
            active_in = 1'b0;
         end else begin
            left_in  = left_ff - (C+1)'(1);
            error_in = minor_step ? (err_sum - {1'b0, major_ff}) : err_sum;
            if (steep_ff) begin
               cur_y_in = y_next;
               if (minor_step) begin
                  cur_x_in = x_next;
               end
            end else begin
               cur_x_in = x_next;
               if (minor_step) begin
                  cur_y_in = y_next;
               end
            end
         end
      end

      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_x_in    = cur_x_ff;
         rsp_y_in    = cur_y_ff;
         rsp_on_in   = !cur_x_ff[C-1] && !cur_y_ff[C-1]
                       && (CMP_W'(cur_x_ff) < CMP_W'(view_width))
                       && (CMP_W'(cur_y_ff) < CMP_W'(view_height));
         rsp_last_in = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         major_ff     <= '0;
         minor_ff     <= '0;
         error_ff     <= '0;
         left_ff      <= '0;
         y_down_ff    <= 1'b0;
         steep_ff     <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         error_ff     <= error_in;
         left_ff      <= left_in;
         y_down_ff    <= y_down_in;
         steep_ff     <= steep_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_x    = rsp_x_ff;
   assign rsp.pixel_y    = rsp_y_ff;
   assign rsp.on_screen  = rsp_on_ff;
   assign rsp.last_pixel = rsp_last_ff;

endmodule
